@@ src/crlu_pkg.sv @@
// crlu_pkg: widths, the item record carried along the solver pipeline
// and the saturating fixed-point helpers; no dependencies
package crlu_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;

  // values carried stage to stage; some fields are reused as the item moves on
  typedef struct packed {
    logic signed [DATA_W-1:0] a11;
    logic signed [DATA_W-1:0] a21;
    logic signed [DATA_W-1:0] a22;
    logic signed [DATA_W-1:0] a23;
    logic signed [DATA_W-1:0] a31;
    logic signed [DATA_W-1:0] a32;
    logic signed [DATA_W-1:0] a33;
    logic signed [DATA_W-1:0] b2;
    logic signed [DATA_W-1:0] b3;
    logic signed [DATA_W-1:0] u12;
    logic signed [DATA_W-1:0] u13;
    logic signed [DATA_W-1:0] u23;
    logic signed [DATA_W-1:0] l22;
    logic signed [DATA_W-1:0] l32;
    logic signed [DATA_W-1:0] l33;
    logic signed [DATA_W-1:0] y1;
    logic signed [DATA_W-1:0] y2;
    logic signed [DATA_W-1:0] y3;
    logic signed [DATA_W-1:0] x1;
    logic signed [DATA_W-1:0] x2;
    logic signed [DATA_W-1:0] m0;
    logic signed [DATA_W-1:0] m1;
    logic signed [DATA_W-1:0] m2;
    logic signed [DATA_W-1:0] m3;
    logic signed [DATA_W-1:0] m4;
    logic signed [DATA_W-1:0] m5;
  } item_t;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // clamp a double-width value to the data range
  function automatic logic signed [DATA_W-1:0] sat(input logic signed [2*DATA_W-1:0] v);
    logic signed [2*DATA_W-1:0] hi;
    logic signed [2*DATA_W-1:0] lo;
    hi = (2*DATA_W)'(SAT_MAX);
    lo = (2*DATA_W)'(SAT_MIN);
    if (v > hi) return SAT_MAX;
    if (v < lo) return SAT_MIN;
    return v[DATA_W-1:0];
  endfunction

  // product shifted right with floor rounding, then clamped
  function automatic logic signed [DATA_W-1:0] fx_mul(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b,
                                                      input int unsigned frac);
    logic signed [2*DATA_W-1:0] p;
    p = a * b;
    return sat(p >>> frac);
  endfunction

  // exact difference, then clamped
  function automatic logic signed [DATA_W-1:0] fx_sub(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    logic [DATA_W:0] d;
    d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (d[DATA_W] != d[DATA_W-1]) return d[DATA_W] ? SAT_MIN : SAT_MAX;
    return d[DATA_W-1:0];
  endfunction

endpackage

@@ src/crlu_if.sv @@
// crlu_in_if / crlu_out_if: valid-ready channels of the 3x3 solver
// standalone, no dependencies
interface crlu_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a11, a12, a13, a21, a22, a23, a31, a32, a33;
  logic signed [31:0] b1, b2, b3;
  modport source (output valid, a11, a12, a13, a21, a22, a23, a31, a32, a33, b1, b2, b3,
                  input ready);
  modport sink   (input valid, a11, a12, a13, a21, a22, a23, a31, a32, a33, b1, b2, b3,
                  output ready);
endinterface

interface crlu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x1, x2, x3, y1, y2, y3;
  logic               singular;
  modport source (output valid, x1, x2, x3, y1, y2, y3, singular, input ready);
  modport sink   (input valid, x1, x2, x3, y1, y2, y3, singular, output ready);
endinterface

@@ src/crlu_div.sv @@
// crlu_div: pipelined fixed-point divider, one quotient bit per stage,
// several lanes in lockstep plus a side band; uses crlu_pkg
module crlu_div #(
  parameter int Lanes    = 1,
  parameter int SideW    = 1,
  parameter int FracBits = crlu_pkg::FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [SideW-1:0]               side_i,
  input  logic [crlu_pkg::DATA_W-1:0]    num_i [Lanes],
  input  logic [crlu_pkg::DATA_W-1:0]    den_i [Lanes],
  output logic                           valid_o,
  output logic [SideW-1:0]               side_o,
  output logic [crlu_pkg::DATA_W-1:0]    quot_o [Lanes]
);
  import crlu_pkg::*;

  localparam int Steps = DATA_W;
  localparam int NumW  = DATA_W + FracBits;
  localparam int CmpW  = 2 * DATA_W;

  logic               vld_q  [Steps+1];
  logic [SideW-1:0]   side_q [Steps+1];
  logic [NumW-1:0]    rem_q  [Steps+1][Lanes];
  logic [DATA_W-1:0]  den_q  [Steps+1][Lanes];
  logic [DATA_W-1:0]  quo_q  [Steps+1][Lanes];
  logic               neg_q  [Steps+1][Lanes];
  logic               ovf_q  [Steps+1][Lanes];

  // operand magnitudes, sign and quotient overflow check
  logic [DATA_W-1:0] nabs [Lanes];
  logic [DATA_W-1:0] dabs [Lanes];
  logic [NumW-1:0]   rem0 [Lanes];
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      nabs[l] = num_i[l][DATA_W-1] ? (~num_i[l] + 1'b1) : num_i[l];
      dabs[l] = den_i[l][DATA_W-1] ? (~den_i[l] + 1'b1) : den_i[l];
      rem0[l] = NumW'(nabs[l]) << FracBits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int l = 0; l < Lanes; l++) begin
        rem_q[0][l] <= rem0[l];
        den_q[0][l] <= dabs[l];
        quo_q[0][l] <= '0;
        neg_q[0][l] <= num_i[l][DATA_W-1] ^ den_i[l][DATA_W-1];
        ovf_q[0][l] <= CmpW'(rem0[l]) >= {dabs[l], {DATA_W{1'b0}}};
      end
    end
  end

  // one compare and subtract per stage, most significant bit first
  for (genvar s = 1; s <= Steps; s++) begin : g_step
    localparam int K = Steps - s;
    logic [NumW-1:0]   rem_d [Lanes];
    logic [DATA_W-1:0] quo_d [Lanes];
    logic [CmpW-1:0]   trial [Lanes];

    always_comb begin
      for (int l = 0; l < Lanes; l++) begin
        trial[l] = CmpW'(den_q[s-1][l]) << K;
        rem_d[l] = rem_q[s-1][l];
        quo_d[l] = quo_q[s-1][l];
        if (CmpW'(rem_q[s-1][l]) >= trial[l]) begin
          rem_d[l] = rem_q[s-1][l] - trial[l][NumW-1:0];
          quo_d[l][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_q[s-1];
        for (int l = 0; l < Lanes; l++) begin
          rem_q[s][l] <= rem_d[l];
          den_q[s][l] <= den_q[s-1][l];
          quo_q[s][l] <= quo_d[l];
          neg_q[s][l] <= neg_q[s-1][l];
          ovf_q[s][l] <= ovf_q[s-1][l];
        end
      end
    end
  end

  // sign and saturation of the magnitude quotient
  logic [DATA_W-1:0] res [Lanes];
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      if (ovf_q[Steps][l]) begin
        res[l] = neg_q[Steps][l] ? SAT_MIN : SAT_MAX;
      end else if (!neg_q[Steps][l]) begin
        res[l] = quo_q[Steps][l][DATA_W-1] ? SAT_MAX : quo_q[Steps][l];
      end else begin
        res[l] = (quo_q[Steps][l] > SAT_MIN) ? SAT_MIN : (~quo_q[Steps][l] + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_q[Steps];
      for (int l = 0; l < Lanes; l++) quot_o[l] <= res[l];
    end
  end

endmodule

@@ src/crout_lu_solve_3x3.sv @@
// crout_lu_solve_3x3: pipelined Crout LU factor and solve of one 3x3 system
// depends on crlu_pkg, crlu_if and crlu_div
//
//  channel  | dir | fields                                  | transfer when
//  in_ch_i  | in  | a11..a33, b1..b3 (signed Q16.16)        | valid && ready
//  out_ch_o | out | x1..x3, y1..y3 (signed Q16.16), singular | valid && ready
//
// one system enters per cycle while the output is not stalled; a result
// passes three 34-stage dividers plus eight multiply and subtract stages
// reset clears every valid bit; the data path holds no reset
// a stalled output freezes the whole pipeline, in ready follows it
module crout_lu_solve_3x3 #(
  parameter int FracBits = crlu_pkg::FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  crlu_in_if.sink   in_ch_i,
  crlu_out_if.source out_ch_o
);
  import crlu_pkg::*;

  localparam int SideW = $bits(item_t);

  logic adv;
  logic out_vq;
  assign adv           = !out_vq || out_ch_o.ready;
  assign in_ch_i.ready = adv;

  // first division: u12, u13, y1 over l11
  item_t             d1_in, d1_out;
  logic [SideW-1:0]  d1_side;
  logic [DATA_W-1:0] d1_num [3], d1_den [3], d1_q [3];
  logic              d1_v;
  always_comb begin
    d1_in     = '0;
    d1_in.a11 = in_ch_i.a11;
    d1_in.a21 = in_ch_i.a21;
    d1_in.a22 = in_ch_i.a22;
    d1_in.a23 = in_ch_i.a23;
    d1_in.a31 = in_ch_i.a31;
    d1_in.a32 = in_ch_i.a32;
    d1_in.a33 = in_ch_i.a33;
    d1_in.b2  = in_ch_i.b2;
    d1_in.b3  = in_ch_i.b3;
    d1_num[0] = in_ch_i.a12;
    d1_num[1] = in_ch_i.a13;
    d1_num[2] = in_ch_i.b1;
    for (int l = 0; l < 3; l++) d1_den[l] = in_ch_i.a11;
  end

  crlu_div #(.Lanes(3), .SideW(SideW), .FracBits(FracBits)) u_div1 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(in_ch_i.valid), .side_i(SideW'(d1_in)),
    .num_i(d1_num), .den_i(d1_den), .valid_o(d1_v), .side_o(d1_side), .quot_o(d1_q)
  );
  assign d1_out = item_t'(d1_side);

  // stage m1: products against the first row of U and y1
  item_t m1_q, m1_d;
  logic  m1_vq;
  always_comb begin
    m1_d     = d1_out;
    m1_d.u12 = d1_q[0];
    m1_d.u13 = d1_q[1];
    m1_d.y1  = d1_q[2];
    m1_d.m0  = fx_mul(d1_out.a21, m1_d.u12, FracBits);
    m1_d.m1  = fx_mul(d1_out.a21, m1_d.u13, FracBits);
    m1_d.m2  = fx_mul(d1_out.a31, m1_d.u12, FracBits);
    m1_d.m3  = fx_mul(d1_out.a31, m1_d.u13, FracBits);
    m1_d.m4  = fx_mul(d1_out.a21, m1_d.y1, FracBits);
    m1_d.m5  = fx_mul(d1_out.a31, m1_d.y1, FracBits);
  end

  // stage a1: l22, l32 and the partial differences
  item_t a1_q, a1_d;
  logic  a1_vq;
  always_comb begin
    a1_d     = m1_q;
    a1_d.l22 = fx_sub(m1_q.a22, m1_q.m0);
    a1_d.a23 = fx_sub(m1_q.a23, m1_q.m1);
    a1_d.l32 = fx_sub(m1_q.a32, m1_q.m2);
    a1_d.a33 = fx_sub(m1_q.a33, m1_q.m3);
    a1_d.b2  = fx_sub(m1_q.b2, m1_q.m4);
    a1_d.b3  = fx_sub(m1_q.b3, m1_q.m5);
  end

  // second division: u23, y2 over l22
  item_t             d2_out;
  logic [SideW-1:0]  d2_side;
  logic [DATA_W-1:0] d2_num [2], d2_den [2], d2_q [2];
  logic              d2_v;
  always_comb begin
    d2_num[0] = a1_q.a23;
    d2_num[1] = a1_q.b2;
    d2_den[0] = a1_q.l22;
    d2_den[1] = a1_q.l22;
  end

  crlu_div #(.Lanes(2), .SideW(SideW), .FracBits(FracBits)) u_div2 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(a1_vq), .side_i(SideW'(a1_q)),
    .num_i(d2_num), .den_i(d2_den), .valid_o(d2_v), .side_o(d2_side), .quot_o(d2_q)
  );
  assign d2_out = item_t'(d2_side);

  // stage m2: products with l32
  item_t m2_q, m2_d;
  logic  m2_vq;
  always_comb begin
    m2_d     = d2_out;
    m2_d.u23 = d2_q[0];
    m2_d.y2  = d2_q[1];
    m2_d.m0  = fx_mul(d2_out.l32, m2_d.u23, FracBits);
    m2_d.m1  = fx_mul(d2_out.l32, m2_d.y2, FracBits);
  end

  // stage a2: l33 and the last forward difference
  item_t a2_q, a2_d;
  logic  a2_vq;
  always_comb begin
    a2_d     = m2_q;
    a2_d.l33 = fx_sub(m2_q.a33, m2_q.m0);
    a2_d.b3  = fx_sub(m2_q.b3, m2_q.m1);
  end

  // third division: y3 over l33
  item_t             d3_out;
  logic [SideW-1:0]  d3_side;
  logic [DATA_W-1:0] d3_num [1], d3_den [1], d3_q [1];
  logic              d3_v;
  assign d3_num[0] = a2_q.b3;
  assign d3_den[0] = a2_q.l33;

  crlu_div #(.Lanes(1), .SideW(SideW), .FracBits(FracBits)) u_div3 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(a2_vq), .side_i(SideW'(a2_q)),
    .num_i(d3_num), .den_i(d3_den), .valid_o(d3_v), .side_o(d3_side), .quot_o(d3_q)
  );
  assign d3_out = item_t'(d3_side);

  // stage m3: back substitution products with x3
  item_t m3_q, m3_d;
  logic  m3_vq;
  always_comb begin
    m3_d    = d3_out;
    m3_d.y3 = d3_q[0];
    m3_d.m0 = fx_mul(d3_out.u23, m3_d.y3, FracBits);
    m3_d.m1 = fx_mul(d3_out.u13, m3_d.y3, FracBits);
  end

  // stage a3: x2 and partial x1
  item_t a3_q, a3_d;
  logic  a3_vq;
  always_comb begin
    a3_d    = m3_q;
    a3_d.x2 = fx_sub(m3_q.y2, m3_q.m0);
    a3_d.x1 = fx_sub(m3_q.y1, m3_q.m1);
  end

  // stage m4: u12 times x2
  item_t m4_q, m4_d;
  logic  m4_vq;
  always_comb begin
    m4_d    = a3_q;
    m4_d.m0 = fx_mul(a3_q.u12, a3_q.x2, FracBits);
  end

  // output stage: x1, pivot check and zeroing
  logic               sing_d;
  logic signed [31:0] x1_d;
  logic signed [31:0] x1_q, x2_q, x3_q, y1_q, y2_q, y3_q;
  logic               sing_q;
  assign x1_d   = fx_sub(m4_q.x1, m4_q.m0);
  assign sing_d = (m4_q.a11 == '0) || (m4_q.l22 == '0) || (m4_q.l33 == '0);

  // valid bits of the local stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vq  <= 1'b0;
      a1_vq  <= 1'b0;
      m2_vq  <= 1'b0;
      a2_vq  <= 1'b0;
      m3_vq  <= 1'b0;
      a3_vq  <= 1'b0;
      m4_vq  <= 1'b0;
      out_vq <= 1'b0;
    end else if (adv) begin
      m1_vq  <= d1_v;
      a1_vq  <= m1_vq;
      m2_vq  <= d2_v;
      a2_vq  <= m2_vq;
      m3_vq  <= d3_v;
      a3_vq  <= m3_vq;
      m4_vq  <= a3_vq;
      out_vq <= m4_vq;
    end
  end

  // data of the local stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q   <= m1_d;
      a1_q   <= a1_d;
      m2_q   <= m2_d;
      a2_q   <= a2_d;
      m3_q   <= m3_d;
      a3_q   <= a3_d;
      m4_q   <= m4_d;
      sing_q <= sing_d;
      x1_q   <= sing_d ? '0 : x1_d;
      x2_q   <= sing_d ? '0 : m4_q.x2;
      x3_q   <= sing_d ? '0 : m4_q.y3;
      y1_q   <= sing_d ? '0 : m4_q.y1;
      y2_q   <= sing_d ? '0 : m4_q.y2;
      y3_q   <= sing_d ? '0 : m4_q.y3;
    end
  end

  assign out_ch_o.valid    = out_vq;
  assign out_ch_o.x1       = x1_q;
  assign out_ch_o.x2       = x2_q;
  assign out_ch_o.x3       = x3_q;
  assign out_ch_o.y1       = y1_q;
  assign out_ch_o.y2       = y2_q;
  assign out_ch_o.y3       = y3_q;
  assign out_ch_o.singular = sing_q;

  // a singular result carries all-zero values
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq && sing_q |-> x1_q == '0 && x2_q == '0 && x3_q == '0 &&
                         y1_q == '0 && y2_q == '0 && y3_q == '0)
    else $error("singular result with nonzero values");

  // input is held off only by a waiting result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch_i.ready |-> out_vq && !out_ch_o.ready)
    else $error("input stalled without output backpressure");

  // a stall freezes the inner stages
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(m4_vq) && $stable(a1_vq) && $stable(m3_vq))
    else $error("pipeline moved during a stall");

  // x3 equals y3 on every result
  a_x3_y3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq |-> x3_q == y3_q)
    else $error("x3 differs from y3");

endmodule
